>>> src/rirs_pkg.sv
// shared types and constants for the register interval range splitter
`timescale 1ns / 1ps
package rirs_pkg;

  localparam int unsigned NumIntervals = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 7;
  localparam logic [16:0] AddrTop = 17'h0FFFF;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_COMMIT = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ARG   = 2'd1,
    ST_TBL_BAD   = 2'd2,
    ST_NOT_CONTIG = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_CELL_SIZE = 1'b0,
    REG_INTERVAL_COUNT = 1'b1
  } reg_idx_e;

  // classified item handed from the front part to the back part
  typedef struct packed {
    func_e       func;
    logic [3:0]  entry_index;
    logic [15:0] address;
    logic [15:0] count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  segment_index;
    logic [21:0] byte_offset;
    logic [22:0] byte_size;
    logic        last;
  } res_t;

endpackage

>>> src/rirs_front.sv
// input side: accepts transactions into a two-entry queue
`timescale 1ns / 1ps
module rirs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rirs_pkg::cmd_t   cmd_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output rirs_pkg::cmd_t   cmd_o
);

  rirs_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign in_ready_o  = fill_q != 2'd2;
  assign cmd_valid_o = fill_q != 2'd0;
  assign cmd_o       = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> src/rirs_back.sv
// execution side: table, commit check, binary searches and segment output
`timescale 1ns / 1ps
module rirs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [6:0]            cfg_data_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  rirs_pkg::cmd_t        cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rirs_pkg::res_t        res_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_SRCH_S = 7'b0000100,
    S_SRCH_E = 7'b0001000,
    S_JOIN   = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e      state_q;
  logic [15:0] start_q [16];
  logic [16:0] len_q   [16];
  logic        ready_q;
  logic [6:0]  cell_q;
  logic [4:0]  icnt_q;

  rirs_pkg::cmd_t cmd_q;
  logic [4:0]  lo_q, hi_q;
  logic [3:0]  i_q, s_q, e_q;
  logic [16:0] end_q;     // last address of previous interval
  logic [16:0] rem_q;
  logic [16:0] tgt;
  logic        is_last_q;
  rirs_pkg::res_t res_q;
  logic        res_v_q;

  logic        cnt_ok;
  logic [4:0]  mid;
  logic [3:0]  lm1;
  logic [16:0] addr_end;  // addr + cnt - 1
  logic [17:0] ival_end;  // start + len - 1 for entry i
  logic [16:0] off, seg_sz;
  logic        out_free;
  logic        take;
  logic        res_load;

  assign cnt_ok   = icnt_q != 5'd0 && icnt_q <= 5'(rirs_pkg::NumIntervals);
  assign mid      = 5'((6'(lo_q) + 6'(hi_q)) >> 1);
  assign lm1      = 4'(lo_q - 5'd1);
  assign addr_end = 17'(cmd_q.address) + 17'(cmd_q.count) - 17'd1;
  assign tgt      = (state_q == S_SRCH_S) ? 17'(cmd_q.address) : addr_end;
  assign ival_end = 18'(start_q[i_q]) + 18'(len_q[i_q]) - 18'd1;
  assign off      = (i_q == s_q) ? 17'(cmd_q.address) - 17'(start_q[i_q]) : 17'd0;
  assign seg_sz   = (i_q == e_q) ? rem_q : len_q[i_q] - off;
  assign out_free = !res_v_q || out_ready_i;
  // a new transaction only starts once the previous result is gone
  assign take     = state_q == S_IDLE && cmd_valid_i && out_free;
  assign res_load = out_free && (state_q == S_OUT || (state_q == S_EMIT && is_last_q));

  assign cmd_ready_o = state_q == S_IDLE && out_free;
  assign out_valid_o = res_v_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.func == rirs_pkg::FUNC_LOAD) begin
      start_q[cmd_i.entry_index] <= cmd_i.address;
      len_q[cmd_i.entry_index]   <= {1'b0, cmd_i.count};
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
  end

  // control, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
      cell_q  <= 7'd2;
      icnt_q  <= 5'd1;
      res_v_q <= 1'b0;
      lo_q <= '0; hi_q <= '0; i_q <= '0; s_q <= '0; e_q <= '0;
      end_q <= '0; rem_q <= '0; is_last_q <= 1'b0; res_q <= '0;
    end else begin
      if (res_load) res_v_q <= 1'b1;
      else if (res_v_q && out_ready_i) res_v_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rirs_pkg::REG_CELL_SIZE: cell_q <= cfg_data_i;
          rirs_pkg::REG_INTERVAL_COUNT: begin
            icnt_q  <= cfg_data_i[4:0];
            ready_q <= 1'b0;
          end
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            unique case (cmd_i.func)
              rirs_pkg::FUNC_LOAD: begin
                ready_q <= 1'b0;
                res_q <= '{status: rirs_pkg::ST_OK, segment_index: '0,
                           byte_offset: '0, byte_size: '0, last: 1'b1};
                state_q <= S_OUT;
              end
              rirs_pkg::FUNC_COMMIT: begin
                ready_q <= 1'b0;
                i_q <= '0;
                end_q <= '0;
                if (!cnt_ok) begin
                  res_q <= '{status: rirs_pkg::ST_BAD_ARG, segment_index: '0,
                             byte_offset: '0, byte_size: '0, last: 1'b1};
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_CHECK;
                end
              end
              rirs_pkg::FUNC_READ: begin
                if (!ready_q || cmd_i.count == 16'd0 || cell_q == 7'd0
                    || cell_q > 7'd64 || !cnt_ok) begin
                  res_q <= '{status: rirs_pkg::ST_BAD_ARG, segment_index: '0,
                             byte_offset: '0, byte_size: '0, last: 1'b1};
                  state_q <= S_OUT;
                end else if (17'(cmd_i.address) + 17'(cmd_i.count) - 17'd1
                             > rirs_pkg::AddrTop) begin
                  res_q <= '{status: rirs_pkg::ST_NOT_CONTIG, segment_index: '0,
                             byte_offset: '0, byte_size: '0, last: 1'b1};
                  state_q <= S_OUT;
                end else begin
                  res_q <= '{status: rirs_pkg::ST_BAD_ARG, segment_index: '0,
                             byte_offset: '0, byte_size: '0, last: 1'b1};
                  lo_q <= '0;
                  hi_q <= icnt_q;
                  state_q <= S_SRCH_S;
                end
              end
              default: begin
                res_q <= '{status: rirs_pkg::ST_BAD_ARG, segment_index: '0,
                           byte_offset: '0, byte_size: '0, last: 1'b1};
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_CHECK: begin
          // one table entry per cycle
          if (len_q[i_q] == 17'd0 || ival_end > 18'(rirs_pkg::AddrTop)
              || (i_q != 4'd0 && end_q >= 17'(start_q[i_q]))) begin
            res_q <= '{status: rirs_pkg::ST_TBL_BAD, segment_index: '0,
                       byte_offset: '0, byte_size: '0, last: 1'b1};
            state_q <= S_OUT;
          end else if (5'(i_q) + 5'd1 == icnt_q) begin
            ready_q <= 1'b1;
            res_q <= '{status: rirs_pkg::ST_OK, segment_index: '0,
                       byte_offset: '0, byte_size: '0, last: 1'b1};
            state_q <= S_OUT;
          end else begin
            end_q <= ival_end[16:0];
            i_q <= i_q + 4'd1;
          end
        end
        S_SRCH_S, S_SRCH_E: begin
          if (lo_q < hi_q) begin
            if (17'(start_q[mid[3:0]]) > tgt) hi_q <= mid;
            else lo_q <= mid + 5'd1;
          end else begin
            i_q <= lm1;
            if (lo_q == 5'd0) begin
              res_q.status <= rirs_pkg::ST_NOT_CONTIG;
              state_q <= S_OUT;
            end else if (state_q == S_SRCH_S) begin
              s_q <= lm1;
              lo_q <= '0;
              hi_q <= icnt_q;
              state_q <= S_SRCH_E;
            end else begin
              e_q <= lm1;
              state_q <= S_JOIN;
            end
          end
          // containment check done on lm1 later via JOIN; see below
        end
        S_JOIN: begin
          // i_q starts at e; verify containment of both ends, then joins
          if (18'(start_q[s_q]) + 18'(len_q[s_q]) - 18'd1 < 18'(cmd_q.address)
              || ival_end < 18'(addr_end) || e_q < s_q) begin
            res_q.status <= rirs_pkg::ST_NOT_CONTIG;
            state_q <= S_OUT;
          end else begin
            i_q <= s_q;
            end_q <= '0;
            state_q <= S_EMIT;
            is_last_q <= 1'b0;
            rem_q <= 17'(cmd_q.count);
          end
        end
        S_EMIT: begin
          if (!is_last_q) begin
            // first pass: check joins s..e-1
            if (i_q == e_q) begin
              is_last_q <= 1'b1;
              i_q <= s_q;
            end else if (17'(start_q[i_q]) + len_q[i_q]
                         != 17'(start_q[i_q + 4'd1])) begin
              res_q.status <= rirs_pkg::ST_NOT_CONTIG;
              state_q <= S_OUT;
            end else begin
              i_q <= i_q + 4'd1;
            end
          end else if (out_free) begin
            res_q.status        <= rirs_pkg::ST_OK;
            res_q.segment_index <= i_q;
            res_q.byte_offset   <= 22'(off) * 22'(cell_q);
            res_q.byte_size     <= 23'(24'(seg_sz) * 24'(cell_q));
            res_q.last          <= i_q == e_q;
            rem_q <= rem_q - seg_sz;
            if (i_q == e_q) state_q <= S_IDLE;
            else i_q <= i_q + 4'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/register_interval_range_splitter.sv
// top level of the register interval range splitter
//
// items arrive on the in_ channel (func, entry_index, address, count) and
// results leave on the out_ channel, both valid/ready. a load or commit
// gives one result; a read gives one result per covered interval, the
// final one flagged by last_o, or a single error result.
// a two-entry queue sits in front of the execution engine, so items are
// taken while the engine works or while a result waits for the receiver.
// a load writes one table entry; a commit checks the entries one by one; a
// read runs two binary searches, checks containment and one join per covered
// interval, then emits the segments in order. the engine handles one item
// at a time and starts the next once the last result has been taken; the
// binary searches and the per-interval passes set that pace.
// reset clears table_ready, sets cell_size 2 and interval_count 1; table
// contents are undefined until loaded.
// a stalled receiver holds the engine; the input queue fills and then
// drops in_ready_o. configuration writes belong in idle periods only.
`timescale 1ns / 1ps
module register_interval_range_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  entry_index_i,
  input  logic [15:0] address_i,
  input  logic [15:0] count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  segment_index_o,
  output logic [21:0] byte_offset_o,
  output logic [22:0] byte_size_o,
  output logic        last_o
);

  rirs_pkg::cmd_t in_cmd, q_cmd;
  rirs_pkg::res_t res;
  logic q_valid, q_ready;

  assign in_cmd.func        = rirs_pkg::func_e'(func_i);
  assign in_cmd.entry_index = entry_index_i;
  assign in_cmd.address     = address_i;
  assign in_cmd.count       = count_i;

  rirs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .cmd_i(in_cmd), .cmd_valid_o(q_valid), .cmd_ready_i(q_ready), .cmd_o(q_cmd)
  );

  rirs_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .res_o(res)
  );

  assign status_o        = res.status;
  assign segment_index_o = res.segment_index;
  assign byte_offset_o   = res.byte_offset;
  assign byte_size_o     = res.byte_size;
  assign last_o          = res.last;

endmodule

>>> src/rirs_checker.sv
// port-level checks for the register interval range splitter
`timescale 1ns / 1ps
module rirs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [21:0] byte_offset_o,
  input logic [22:0] byte_size_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_size_o))
    else $error("result dropped while stalled");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rirs_pkg::ST_OK |-> last_o)
    else $error("error result not marked last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rirs_pkg::ST_OK |->
      byte_size_o == 23'd0 && byte_offset_o == 22'd0)
    else $error("error result carries data");

endmodule

bind register_interval_range_splitter rirs_checker u_rirs_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .status_o,
  .byte_offset_o, .byte_size_o, .last_o
);

>>> dv/register_interval_range_splitter_checker.sv
// checker: predicts the segment results of each transaction and compares them
`timescale 1ns / 1ps
module register_interval_range_splitter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [3:0]  entry_index_i,
  input  logic [15:0] address_i,
  input  logic [15:0] count_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [3:0]  segment_index_i,
  input  logic [21:0] byte_offset_i,
  input  logic [22:0] byte_size_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          seg_count_o
);

  logic [15:0] span_start[rirs_pkg::NumIntervals];
  logic [16:0] span_len[rirs_pkg::NumIntervals];
  bit          tbl_ready;
  logic [6:0]  cell_bytes;
  logic [4:0]  used_count;
  rirs_pkg::res_t segments_due[$];

  function automatic bit used_count_ok();
    return used_count != 0 && used_count <= rirs_pkg::NumIntervals;
  endfunction

  // binary search for the interval holding addr, -1 if none
  function automatic int find_interval(int addr);
    int lo, hi, mid;
    lo = 0;
    hi = used_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (int'(span_start[mid]) > addr) hi = mid;
      else lo = mid + 1;
    end
    if (lo == 0) return -1;
    lo = lo - 1;
    if (int'(span_start[lo]) + int'(span_len[lo]) - 1 >= addr) return lo;
    return -1;
  endfunction

  function automatic rirs_pkg::status_e validate_table();
    int last_end, s, n;
    last_end = 0;
    tbl_ready = 0;
    if (!used_count_ok()) return rirs_pkg::ST_BAD_ARG;
    for (int i = 0; i < used_count; i++) begin
      s = span_start[i];
      n = span_len[i];
      if (n == 0 || s + n - 1 > 'hFFFF) return rirs_pkg::ST_TBL_BAD;
      if (i != 0 && last_end >= s) return rirs_pkg::ST_TBL_BAD;
      last_end = s + n - 1;
    end
    tbl_ready = 1;
    return rirs_pkg::ST_OK;
  endfunction

  function automatic void push_status(rirs_pkg::status_e st);
    rirs_pkg::res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    segments_due.push_back(r);
  endfunction

  function automatic void predict_read(int addr, int cnt);
    int first, final_idx, remaining, off, sz;
    rirs_pkg::res_t r;
    if (!tbl_ready || cnt == 0 || cell_bytes == 0 || cell_bytes > 64 || !used_count_ok()) begin
      push_status(rirs_pkg::ST_BAD_ARG);
      return;
    end
    if (addr + cnt - 1 > 'hFFFF) begin
      push_status(rirs_pkg::ST_NOT_CONTIG);
      return;
    end
    first = find_interval(addr);
    final_idx = find_interval(addr + cnt - 1);
    if (first < 0 || final_idx < 0 || final_idx < first) begin
      push_status(rirs_pkg::ST_NOT_CONTIG);
      return;
    end
    for (int i = first; i < final_idx; i++) begin
      if (int'(span_start[i]) + int'(span_len[i]) != int'(span_start[i+1])) begin
        push_status(rirs_pkg::ST_NOT_CONTIG);
        return;
      end
    end
    remaining = cnt;
    for (int i = first; i <= final_idx; i++) begin
      off = (i == first) ? addr - int'(span_start[i]) : 0;
      sz = (i == final_idx) ? remaining : int'(span_len[i]) - off;
      remaining -= sz;
      r.status = rirs_pkg::ST_OK;
      r.segment_index = i[3:0];
      r.byte_offset = 22'(off * cell_bytes);
      r.byte_size = 23'(sz * cell_bytes);
      r.last = (i == final_idx);
      segments_due.push_back(r);
    end
  endfunction

  function automatic void predict_item(rirs_pkg::func_e f, logic [3:0] idx,
                                       logic [15:0] addr, logic [15:0] cnt);
    case (f)
      rirs_pkg::FUNC_LOAD: begin
        span_start[idx] = addr;
        span_len[idx] = {1'b0, cnt};
        tbl_ready = 0;
        push_status(rirs_pkg::ST_OK);
      end
      rirs_pkg::FUNC_COMMIT: push_status(validate_table());
      rirs_pkg::FUNC_READ: predict_read(int'(addr), int'(cnt));
      default: push_status(rirs_pkg::ST_BAD_ARG);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rirs_pkg::res_t got, want;
    if (!rst_ni) begin
      tbl_ready = 0;
      cell_bytes = 7'd2;
      used_count = 5'd1;
      segments_due.delete();
      fail_count_o = 0;
      seg_count_o = 0;
      for (int i = 0; i < rirs_pkg::NumIntervals; i++) begin
        span_start[i] = '0;
        span_len[i] = '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rirs_pkg::REG_CELL_SIZE) begin
          cell_bytes = cfg_data_i;
        end else begin
          used_count = cfg_data_i[4:0];
          tbl_ready = 0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = '{status_i, segment_index_i, byte_offset_i, byte_size_i, last_i};
        seg_count_o++;
        if (segments_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: status %0d seg %0d off %0d size %0d last %0b",
                     got.status, got.segment_index, got.byte_offset, got.byte_size,
                     got.last);
        end else begin
          want = segments_due.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"result mismatch: expected status %0d seg %0d off %0d size %0d ",
                        "last %0b, got status %0d seg %0d off %0d size %0d last %0b"},
                       want.status, want.segment_index, want.byte_offset, want.byte_size,
                       want.last, got.status, got.segment_index, got.byte_offset,
                       got.byte_size, got.last);
          end
        end
      end
      // a result and a new transaction may meet in one edge; results come from older items
      if (in_valid_i && in_ready_i)
        predict_item(rirs_pkg::func_e'(func_i), entry_index_i, address_i, count_i);
    end
    pending_o = segments_due.size();
  end

endmodule

>>> dv/register_interval_range_splitter_tb.sv
// testbench top: stimulus for the interval range splitter and the final verdict
`timescale 1ns / 1ps
module register_interval_range_splitter_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = rirs_pkg::REG_CELL_SIZE;
  logic [6:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = rirs_pkg::FUNC_LOAD;
  logic [3:0]  entry_index_i = '0;
  logic [15:0] address_i = '0;
  logic [15:0] count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  segment_index_o;
  logic [21:0] byte_offset_o;
  logic [22:0] byte_size_o;
  logic        last_o;
  int          fail_count, pending, seg_count;

  int          items_sent = 0;
  int          phases_run = 0;
  bit          quiet = 0;
  int          stall_left = 0;
  int          lay_start[rirs_pkg::NumIntervals];
  int          lay_len[rirs_pkg::NumIntervals];
  int          lay_count = 1;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  register_interval_range_splitter i_dut (.*);

  register_interval_range_splitter_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .func_i, .entry_index_i, .address_i, .count_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .segment_index_i(segment_index_o), .byte_offset_i(byte_offset_o),
    .byte_size_i(byte_size_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .seg_count_o(seg_count)
  );

  // receiver back-pressure in short bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(rirs_pkg::func_e f, int idx, int addr, int cnt);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    entry_index_i <= idx[3:0];
    address_i <= addr[15:0];
    count_i <= cnt[15:0];
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  // register writes only once the engine has drained
  task automatic write_reg(rirs_pkg::reg_idx_e idx, int value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[6:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // lays out lay_count intervals, mostly valid, sometimes broken on purpose
  task automatic load_layout(bit broken);
    bit wide;
    int pos, maxlen, j;
    wide = ($urandom_range(0, 4) == 0);
    maxlen = wide ? 65536 / lay_count : 40;
    if (maxlen > 65535) maxlen = 65535;
    pos = wide ? 0 : $urandom_range(0, 200);
    for (int i = 0; i < lay_count; i++) begin
      if (!wide && $urandom_range(0, 5) == 0) pos += $urandom_range(1, 5);
      lay_start[i] = pos;
      lay_len[i] = $urandom_range(1, maxlen);
      if (wide && i == lay_count - 1) lay_len[i] = (65536 - pos > 65535) ? 65535 : 65536 - pos;
      pos += lay_len[i];
    end
    if (broken) begin
      j = $urandom_range(0, lay_count - 1);
      case ($urandom_range(0, 2))
        0: lay_len[j] = 0;
        1: if (j > 0) lay_start[j] = lay_start[j-1]; else lay_len[j] = 0;
        default: begin
          lay_start[j] = 'hFFFF;
          lay_len[j] = 2;
        end
      endcase
    end
    for (int i = 0; i < lay_count; i++)
      send_item(rirs_pkg::FUNC_LOAD, i, lay_start[i], lay_len[i]);
  endtask

  task automatic random_read();
    int lo, hi, addr, cnt;
    lo = lay_start[0];
    hi = lay_start[lay_count-1] + lay_len[lay_count-1] - 1;
    if (hi > 'hFFFF) hi = 'hFFFF;
    if (hi < lo) hi = lo;
    addr = $urandom_range(lo, hi);
    if ($urandom_range(0, 1) == 0) cnt = $urandom_range(1, 8);
    else cnt = $urandom_range(1, hi - addr + 1);
    if ($urandom_range(0, 9) == 0) cnt++;
    if (cnt > 65535) cnt = 65535;
    send_item(rirs_pkg::FUNC_READ, 0, addr, cnt);
  endtask

  initial begin
    int cs, ic;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: not ready, reserved code, full-span table and the address top
    send_item(rirs_pkg::FUNC_READ, 0, 0, 1);
    send_item(rirs_pkg::FUNC_RSVD, 15, 'hFFFF, 'hFFFF);
    for (int i = 0; i < rirs_pkg::NumIntervals; i++)
      send_item(rirs_pkg::FUNC_LOAD, i, i * 4096, 4096);
    send_item(rirs_pkg::FUNC_COMMIT, 0, 0, 0);
    send_item(rirs_pkg::FUNC_READ, 0, 5, 10);
    write_reg(rirs_pkg::REG_INTERVAL_COUNT, 16);
    write_reg(rirs_pkg::REG_CELL_SIZE, 64);
    send_item(rirs_pkg::FUNC_COMMIT, 0, 0, 0);
    send_item(rirs_pkg::FUNC_READ, 0, 0, 65535);
    send_item(rirs_pkg::FUNC_READ, 0, 1, 65535);
    send_item(rirs_pkg::FUNC_READ, 0, 2, 65535);
    send_item(rirs_pkg::FUNC_READ, 0, 'hFFFF, 1);
    send_item(rirs_pkg::FUNC_READ, 0, 100, 0);
    send_item(rirs_pkg::FUNC_READ, 0, 4000, 5000);
    write_reg(rirs_pkg::REG_CELL_SIZE, 0);
    send_item(rirs_pkg::FUNC_READ, 0, 0, 1);
    write_reg(rirs_pkg::REG_INTERVAL_COUNT, 0);
    send_item(rirs_pkg::FUNC_COMMIT, 0, 0, 0);
    write_reg(rirs_pkg::REG_INTERVAL_COUNT, 31);
    send_item(rirs_pkg::FUNC_COMMIT, 0, 0, 0);

    // random phases: settings, table, commit, then mostly well-formed reads
    while (items_sent < 300) begin
      phases_run++;
      cs = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? 127 : 0)
                                       : $urandom_range(1, 64);
      if ($urandom_range(0, 3) == 0) cs = ($urandom_range(0, 1) != 0) ? 1 : 64;
      ic = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16);
      write_reg(rirs_pkg::REG_CELL_SIZE, cs);
      write_reg(rirs_pkg::REG_INTERVAL_COUNT, ic);
      lay_count = (ic > 16) ? 16 : ic;
      quiet = (items_sent > 260);
      load_layout($urandom_range(0, 6) == 0);
      send_item(rirs_pkg::FUNC_COMMIT, 0, 0, 0);
      repeat ($urandom_range(8, 20)) begin
        case ($urandom_range(0, 9))
          0: send_item(rirs_pkg::FUNC_READ, 0, $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
          1: send_item(rirs_pkg::func_e'($urandom_range(0, 1) != 0 ? rirs_pkg::FUNC_RSVD
                                                                   : rirs_pkg::FUNC_COMMIT),
                       $urandom_range(0, 15), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
          default: random_read();
        endcase
      end
      if ($urandom_range(0, 7) == 0)
        send_item(rirs_pkg::FUNC_LOAD, $urandom_range(0, 15), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d items in %0d random phases plus directed cases, %0d results checked",
             items_sent, phases_run, seg_count);
    $display("cell sizes 0..127 edges, interval counts 0..31 edges, broken and full-span tables");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results still expected", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
